@@ hdl/pts_pkg.sv @@
package pts_pkg;

  // Default sizing
  localparam int TASKS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  // Most results one tick can give
  localparam int MAX_OUT = 16;
  localparam int KW      = $clog2(MAX_OUT + 1);

  // Request opcodes
  localparam logic [2:0] OP_REGISTER   = 3'd0;
  localparam logic [2:0] OP_UNREGISTER = 3'd1;
  localparam logic [2:0] OP_ENABLE     = 3'd2;
  localparam logic [2:0] OP_DISABLE    = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_QUERY      = 3'd6;
  localparam logic [2:0] OP_COUNT      = 3'd7;

endpackage

@@ hdl/periodic_task_scheduler_unit.sv @@
// Operation: a request walks the packed task table one slot per cycle, but a
// tick holds its walk while a due task waits on a full result register. A
// non-tick request posts its result after the walk; a tick compares each slot
// in turn and stops at the table end or after MAX_OUT due tasks. One request
// at a time: none is taken until the last is done, so the walk bounds the rate.
// Reset: synchronous, active high; empties the table and drops any result.
module periodic_task_scheduler_unit #(
  parameter int TASKS     = pts_pkg::TASKS_DEF,
  parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        opcode,
  input  logic [15:0]       task_key,
  input  logic [31:0]       interval_req,
  input  logic signed [7:0] priority_req,
  input  logic [31:0]       now_ms,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic              fired,
  output logic [15:0]       fired_key,
  output logic [4:0]        task_count,
  output logic              last
);

  localparam int IW = $clog2(TASKS);
  localparam int CW = $clog2(TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_TICK,
    S_TFIN
  } state_t;

  state_t state;

  // Task table, packed at the front in service order
  logic [15:0]          slot_key      [TASKS];
  logic [31:0]          slot_interval [TASKS];
  logic signed [7:0]    slot_priority [TASKS];
  logic                 slot_enabled  [TASKS];
  logic [TIME_BITS-1:0] slot_last_run [TASKS];
  logic [CW-1:0]        count;

  // Latched request
  logic [2:0]           op_r;
  logic [15:0]          key_r;
  logic [31:0]          interval_r;
  logic signed [7:0]    prio_r;
  logic [TIME_BITS-1:0] now_r;

  // Walk state
  logic [CW-1:0]        scan_i;
  logic                 found;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        pos;
  logic                 pos_set;
  logic [KW_W-1:0]      k;
  logic                 has_pend;
  logic [15:0]          pend_key;

  localparam int KW_W = pts_pkg::KW;

  // Combinational helpers
  logic [IW-1:0]           sel;
  logic [IW-1:0]           idx_sel;
  logic [IW-1:0]           pos_sel;
  logic [TIME_BITS-1:0]    elapsed;
  logic                    due;
  logic                    key_hit;
  logic                    prio_lower;
  logic                    out_free;
  logic                    out_load;
  logic                    tick_end;
  logic                    full;
  logic                    op_ok;
  logic [CW-1:0]           count_new;
  logic [CW+4:0]           count_wide;
  logic [4:0]              tc;
  logic [TIME_BITS+31:0]   now_ext;
  logic [TIME_BITS+31:0]   elapsed_ext;
  logic [TIME_BITS+31:0]   interval_ext;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign sel     = scan_i[IW-1:0];
  assign idx_sel = idx[IW-1:0];
  assign pos_sel = pos[IW-1:0];
  assign now_ext = {TIME_BITS'(0), now_ms};

  // Shared per-slot compare unit
  assign elapsed      = now_r - slot_last_run[sel];
  assign elapsed_ext  = {32'd0, elapsed};
  assign interval_ext = {TIME_BITS'(0), slot_interval[sel]};
  assign due          = slot_enabled[sel] && (elapsed_ext >= interval_ext);
  assign key_hit      = (slot_key[sel] == key_r);
  assign prio_lower   = (slot_priority[sel] < prio_r);

  assign full     = (count == CW'(TASKS));
  assign tick_end = (scan_i == count) || (k == KW_W'(pts_pkg::MAX_OUT));

  // Result register load
  always_comb begin
    case (state)
      S_ACT:   out_load = out_free;
      S_TICK:  out_load = !tick_end && due && has_pend && out_free;
      S_TFIN:  out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  // Outcome of a non-tick request
  always_comb begin
    op_ok     = 1'b1;
    count_new = count;
    case (op_r)
      pts_pkg::OP_REGISTER: begin
        op_ok = !found && !full;
        if (op_ok) count_new = count + CW'(1);
      end
      pts_pkg::OP_UNREGISTER: begin
        op_ok = found;
        if (op_ok) count_new = count - CW'(1);
      end
      pts_pkg::OP_ENABLE,
      pts_pkg::OP_DISABLE,
      pts_pkg::OP_QUERY: op_ok = found;
      pts_pkg::OP_CLEAR: count_new = '0;
      default: op_ok = 1'b1;
    endcase
  end

  assign count_wide = {5'd0, count_new};
  assign tc         = count_wide[4:0];

  // Sequencer, table and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= opcode;
            key_r      <= task_key;
            interval_r <= interval_req;
            prio_r     <= priority_req;
            now_r      <= now_ext[TIME_BITS-1:0];
            scan_i     <= '0;
            found      <= 1'b0;
            pos_set    <= 1'b0;
            k          <= '0;
            has_pend   <= 1'b0;
            state      <= (opcode == pts_pkg::OP_TICK) ? S_TICK : S_SCAN;
          end
        end

        // Key lookup and insert position, one slot per cycle
        S_SCAN: begin
          if (scan_i == count) begin
            if (!pos_set) pos <= count;
            state <= S_ACT;
          end else begin
            if (key_hit) begin
              found <= 1'b1;
              idx   <= scan_i;
            end
            if (!pos_set && prio_lower) begin
              pos     <= scan_i;
              pos_set <= 1'b1;
            end
            scan_i <= scan_i + CW'(1);
          end
        end

        // Apply the request and post its result
        S_ACT: begin
          if (out_free) begin
            case (op_r)
              pts_pkg::OP_REGISTER: begin
                if (op_ok) begin
                  for (int j = 1; j < TASKS; j++) begin
                    if (CW'(j) > pos && CW'(j) <= count) begin
                      slot_key[j]      <= slot_key[j-1];
                      slot_interval[j] <= slot_interval[j-1];
                      slot_priority[j] <= slot_priority[j-1];
                      slot_enabled[j]  <= slot_enabled[j-1];
                      slot_last_run[j] <= slot_last_run[j-1];
                    end
                  end
                  slot_key[pos_sel]      <= key_r;
                  slot_interval[pos_sel] <= interval_r;
                  slot_priority[pos_sel] <= prio_r;
                  slot_enabled[pos_sel]  <= 1'b1;
                  slot_last_run[pos_sel] <= now_r;
                end
              end
              pts_pkg::OP_UNREGISTER: begin
                if (op_ok) begin
                  for (int j = 0; j < TASKS - 1; j++) begin
                    if (CW'(j) >= idx && CW'(j + 1) < count) begin
                      slot_key[j]      <= slot_key[j+1];
                      slot_interval[j] <= slot_interval[j+1];
                      slot_priority[j] <= slot_priority[j+1];
                      slot_enabled[j]  <= slot_enabled[j+1];
                      slot_last_run[j] <= slot_last_run[j+1];
                    end
                  end
                end
              end
              pts_pkg::OP_ENABLE: begin
                if (op_ok) begin
                  slot_enabled[idx_sel]  <= 1'b1;
                  slot_last_run[idx_sel] <= now_r;
                end
              end
              pts_pkg::OP_DISABLE: begin
                if (op_ok) slot_enabled[idx_sel] <= 1'b0;
              end
              default: ;
            endcase
            count     <= count_new;
            ok        <= op_ok;
            fired     <= 1'b0;
            fired_key <= '0;
            task_count <= tc;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end

        // Tick walk; one due task is held back so the final one gets last
        S_TICK: begin
          if (tick_end) begin
            state <= S_TFIN;
          end else if (due) begin
            if (!has_pend || out_free) begin
              if (has_pend) begin
                ok         <= 1'b1;
                fired      <= 1'b1;
                fired_key  <= pend_key;
                task_count <= tc;
                last       <= 1'b0;
              end
              pend_key           <= slot_key[sel];
              has_pend           <= 1'b1;
              slot_last_run[sel] <= now_r;
              k                  <= k + KW_W'(1);
              scan_i             <= scan_i + CW'(1);
            end
          end else begin
            scan_i <= scan_i + CW'(1);
          end
        end

        // Final tick result
        S_TFIN: begin
          if (out_free) begin
            ok         <= 1'b1;
            fired      <= has_pend;
            fired_key  <= has_pend ? pend_key : 16'd0;
            task_count <= tc;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/pts_checker.sv @@
module pts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic        fired,
  input logic [15:0] fired_key,
  input logic        last
);

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("scheduler took a request while busy");

  // A fired task always reports success
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> ok)
    else $error("fired result without ok");

  // A result naming no task closes its request and carries a zero key
  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fired |-> last && (fired_key == 16'd0))
    else $error("non-fired result malformed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fired_key) && $stable(last))
    else $error("result changed while stalled");

endmodule

bind periodic_task_scheduler_unit pts_checker u_pts_checker (.*);
